### rtl/btk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btk_pkg: shared types and constants of the bounded top-k table
// Sizes, payload beats, status codes, controller commands and states.
// ----------------------------------------------------------------------------
package btk_pkg;

  // Table size and derived widths
  localparam int MAX_ENTRIES = 16;
  localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int CMP_W       = (CAP_W > COUNT_W) ? CAP_W : COUNT_W;
  localparam int ID_W        = 16;
  localparam int SCORE_W     = 16;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_IDX_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  // Item actions
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_ADDED_MIN = 3'd1,
    ST_EVICTED   = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_DELETED   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef struct packed {
    logic               action;
    logic [ID_W-1:0]    entry_id;
    logic [SCORE_W-1:0] score;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    evicted_id;
    logic [SCORE_W-1:0] min_score;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              commit;
  } ctrl_cmd_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_READ,
    CS_DRAIN,
    CS_COMMIT
  } ctrl_state_t;

endpackage

### rtl/btk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btk_ctrl: sequencer of the bounded top-k table
// Takes a start beat, sweeps every slot once, then commits the update.
// ----------------------------------------------------------------------------
module btk_ctrl import btk_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  ctrl_state_t       state, state_next;
  logic [SLOT_W-1:0] rd_addr, rd_addr_next;

  // State and sweep address registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= CS_IDLE;
      rd_addr <= '0;
    end else begin
      state   <= state_next;
      rd_addr <= rd_addr_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    rd_addr_next = rd_addr;
    cmd          = '0;
    cmd.rd_addr  = rd_addr;
    busy         = 1'b1;
    unique case (state)
      CS_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load     = 1'b1;
          rd_addr_next = '0;
          state_next   = CS_READ;
        end
      end
      CS_READ: begin
        cmd.rd_en    = 1'b1;
        rd_addr_next = rd_addr + SLOT_W'(1);
        if (rd_addr == SLOT_W'(MAX_ENTRIES - 1)) begin
          state_next = CS_DRAIN;
        end
      end
      CS_DRAIN: begin
        state_next = CS_COMMIT;
      end
      CS_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = CS_IDLE;
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

### rtl/btk_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btk_datapath: slot store, sweep accumulators and commit logic
// Holds the slots, finds id, free slot and runner-up minimum in one sweep.
// ----------------------------------------------------------------------------
module btk_datapath import btk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ctrl_cmd_t        cmd,
  input  item_t            item,
  input  logic [CAP_W-1:0] capacity,
  output result_t          result,
  output logic             done
);

  // Slot store
  logic [ID_W-1:0]    mem_id    [MAX_ENTRIES];
  logic [SCORE_W-1:0] mem_score [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid;

  // Latched item
  logic               act_q;
  logic [ID_W-1:0]    id_q;
  logic [SCORE_W-1:0] score_q;

  // Read pipeline
  logic               rd_vld;
  logic [SLOT_W-1:0]  rd_idx;
  logic [ID_W-1:0]    rd_id;
  logic [SCORE_W-1:0] rd_score;

  // Sweep accumulators
  logic               found;
  logic [SLOT_W-1:0]  found_idx;
  logic               free_found;
  logic [SLOT_W-1:0]  free_idx;
  logic               best_vld;
  logic [SLOT_W-1:0]  best_idx;
  logic [SCORE_W-1:0] best_score;
  logic [ID_W-1:0]    best_id;

  // Table state
  logic [COUNT_W-1:0] held_count;
  logic [SLOT_W-1:0]  min_slot;
  logic [SCORE_W-1:0] min_score_q;
  logic [ID_W-1:0]    min_id_q;

  // Commit values
  logic [MAX_ENTRIES-1:0] valid_next;
  logic [COUNT_W-1:0]     held_count_next;
  logic [SLOT_W-1:0]      min_slot_next;
  logic [SCORE_W-1:0]     min_score_next;
  logic [ID_W-1:0]        min_id_next;
  status_t                status_next;
  logic [ID_W-1:0]        evicted_next;
  logic                   mem_we;
  logic [SLOT_W-1:0]      mem_waddr;
  logic [CMP_W-1:0]       eff_cap;
  logic                   full;
  logic                   slot_hit;

  // Write at commit, read the sweep address
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_id[mem_waddr]    <= id_q;
      mem_score[mem_waddr] <= score_q;
    end
    rd_id    <= mem_id[cmd.rd_addr];
    rd_score <= mem_score[cmd.rd_addr];
    rd_idx   <= cmd.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
    end
  end

  assign slot_hit = valid[rd_idx];

  // Latch the item and accumulate over the sweep
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q      <= item.action;
      id_q       <= item.entry_id;
      score_q    <= item.score;
      found      <= 1'b0;
      free_found <= 1'b0;
      best_vld   <= 1'b0;
    end else if (rd_vld) begin
      if (slot_hit && rd_id == id_q && !found) begin
        found     <= 1'b1;
        found_idx <= rd_idx;
      end
      if (!slot_hit && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      // ascending sweep with strict compare keeps the lowest index on ties
      if (slot_hit && rd_idx != min_slot && (!best_vld || rd_score < best_score)) begin
        best_vld   <= 1'b1;
        best_idx   <= rd_idx;
        best_score <= rd_score;
        best_id    <= rd_id;
      end
    end
  end

  // Clamp capacity and decide the update
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity);
    end
    full = CMP_W'(held_count) >= eff_cap;

    valid_next      = valid;
    held_count_next = held_count;
    min_slot_next   = min_slot;
    min_score_next  = min_score_q;
    min_id_next     = min_id_q;
    status_next     = ST_REJECTED;
    evicted_next    = '0;
    mem_we          = 1'b0;
    mem_waddr       = free_idx;

    if (act_q == ACT_INSERT) begin
      if (found) begin
        status_next = ST_REJECTED;
      end else if (!full) begin
        if (free_found) begin
          mem_we                = cmd.commit;
          mem_waddr             = free_idx;
          valid_next[free_idx]  = 1'b1;
          held_count_next       = held_count + COUNT_W'(1);
          if (held_count == '0 || score_q < min_score_q) begin
            min_slot_next  = free_idx;
            min_score_next = score_q;
            min_id_next    = id_q;
            status_next    = ST_ADDED_MIN;
          end else begin
            status_next = ST_ADDED;
          end
        end
      end else if (held_count != '0 && valid[min_slot] && score_q > min_score_q) begin
        // replace the minimum in place, then pick the lower of it and the runner-up
        mem_we       = cmd.commit;
        mem_waddr    = min_slot;
        evicted_next = min_id_q;
        status_next  = ST_EVICTED;
        if (!best_vld || score_q < best_score ||
            (score_q == best_score && min_slot < best_idx)) begin
          min_slot_next  = min_slot;
          min_score_next = score_q;
          min_id_next    = id_q;
        end else begin
          min_slot_next  = best_idx;
          min_score_next = best_score;
          min_id_next    = best_id;
        end
      end
    end else begin
      if (!found) begin
        status_next = ST_NOT_FOUND;
      end else begin
        status_next           = ST_DELETED;
        valid_next[found_idx] = 1'b0;
        if (held_count != '0) begin
          held_count_next = held_count - COUNT_W'(1);
        end
        if (found_idx == min_slot) begin
          if (best_vld) begin
            min_slot_next  = best_idx;
            min_score_next = best_score;
            min_id_next    = best_id;
          end else begin
            min_slot_next  = '0;
            min_score_next = '0;
            min_id_next    = '0;
          end
        end
      end
    end
  end

  // Commit state and register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      held_count <= '0;
      min_slot   <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cmd.commit) begin
        valid      <= valid_next;
        held_count <= held_count_next;
        min_slot   <= min_slot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      min_score_q        <= min_score_next;
      min_id_q           <= min_id_next;
      result.status      <= status_next;
      result.evicted_id  <= evicted_next;
      result.entry_count <= held_count_next;
      result.min_score   <= (held_count_next != '0 && valid_next[min_slot_next]) ?
                            min_score_next : '0;
    end
  end

  // Count tracks the valid slots
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    held_count == COUNT_W'($countones(valid)))
    else $error("held count differs from number of valid slots");

  // A non-empty table always points at a valid minimum slot
  a_min_valid: assert property (@(posedge clk) disable iff (rst)
    (held_count != '0) |-> valid[min_slot])
    else $error("minimum slot not valid while table holds entries");

  // Count never runs past the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= COUNT_W'(MAX_ENTRIES))
    else $error("held count exceeds table size");

  // Every commit is followed by a result beat
  a_done_after_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> done)
    else $error("commit without result beat");

endmodule

### rtl/bounded_top_k_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_top_k_table: capacity-bounded table tracking its minimum score
// Inserts and deletes (id, score) entries, evicting the minimum when full.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: present item and raise start; the beat is taken on a
//   clock edge where start is high and busy is low.
//   Result channel: result is valid for exactly one cycle while done is
//   high; the receiver cannot stall, so it must capture it then.
//   Timing: the controller reads every slot (CS_READ), waits for the last
//   read data (CS_DRAIN), then commits; done and result are registered from
//   the commit. busy drops in the cycle the result shows, so the next beat
//   is taken at the edge ending that cycle; the sweep of the slot store's
//   single read port, one slot a cycle, sets the pace.
//   Configuration: APB, capacity_limit at byte address 0, readable; the user
//   writes it only while the block is idle, unenforced; pready stays high.
//   Reset (synchronous, active high): table empties, capacity_limit
//   returns to 16, no result beat is pending.
// ----------------------------------------------------------------------------
module bounded_top_k_table import btk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  item_t              item,
  output logic               done,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [CAP_W-1:0] capacity;
  ctrl_cmd_t        cmd;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1:2] == REG_IDX_CAPACITY;

  // Capacity register write
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Register read back
  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(PDATA_W - CAP_W){1'b0}}, capacity};
    end
  end

  btk_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  btk_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .item     (item),
    .capacity (capacity),
    .result   (result),
    .done     (done)
  );

endmodule
